@@ src/stis_pkg.sv @@
// ----------------------------------------------------------------------------
// stis_pkg: shared types and constants of the sorted table
// Request and response formats, status and operation codes, and the
// sequencer states of the table engine.
// ----------------------------------------------------------------------------
package stis_pkg;

    localparam int VALUE_W = 32;
    localparam int POS_W   = 6;
    localparam int USED_W  = 7;
    localparam int STAT_W  = 2;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STAT_W-1:0] ST_ABSENT = 2'd2;

    typedef struct packed {
        logic                      operation;
        logic signed [VALUE_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [USED_W-1:0] entries_used;
        logic [POS_W-1:0]  position;
        logic [STAT_W-1:0] status;
    } rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_START,
        S_INS_SHIFT,
        S_INS_LAST,
        S_SRCH_ISSUE,
        S_SRCH_CMP,
        S_RESP
    } state_t;

endpackage

@@ src/stis_engine.sv @@
// ----------------------------------------------------------------------------
// stis_engine: table memory and insert/search sequencer
// Holds the sorted entries in a single-port-write, registered-read memory.
// Inserts shift entries up one per cycle; searches halve the range with
// each probe, a registered memory read followed by a compare.
// ----------------------------------------------------------------------------
module stis_engine #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           req_valid,
    output logic           req_ready,
    input  stis_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output stis_pkg::rsp_t rsp
);
    import stis_pkg::*;

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic signed [VALUE_W-1:0] mem [TABLE_DEPTH];

    state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic                      op_reg, op_next;
    logic signed [VALUE_W-1:0] value_reg, value_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [CW-1:0] lo_reg, lo_next;
    logic [CW-1:0] hi_reg, hi_next;
    logic [IW-1:0] mid_reg, mid_next;
    logic [IW-1:0] pos_reg, pos_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic signed [VALUE_W-1:0] rd_data_reg;

    logic                      wr_en;
    logic [IW-1:0]             wr_addr;
    logic signed [VALUE_W-1:0] wr_data;
    logic                      rd_en;
    logic [IW-1:0]             rd_addr;

    logic          is_full;
    logic          is_empty;
    logic          shift_more;
    logic          idx_is_one;
    logic          srch_open;
    logic          hit;
    logic [CW:0]   mid_sum;
    logic [IW-1:0] mid_calc;

    assign is_full    = (count_reg == CW'(TABLE_DEPTH));
    assign is_empty   = (count_reg == '0);
    assign shift_more = (rd_data_reg > value_reg);
    assign idx_is_one = (idx_reg == IW'(1));
    assign srch_open  = (lo_reg < hi_reg);
    assign hit        = (rd_data_reg == value_reg);
    assign mid_sum    = {1'b0, lo_reg} + {1'b0, hi_reg} - (CW + 1)'(1);
    assign mid_calc   = mid_sum[IW:1];

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (req_valid) begin
                    state_next = (req.operation == OP_SEARCH) ? S_SRCH_ISSUE : S_INS_START;
                end
            end
            S_INS_START: begin
                state_next = (is_full || is_empty) ? S_RESP : S_INS_SHIFT;
            end
            S_INS_SHIFT: begin
                if (!shift_more) begin
                    state_next = S_RESP;
                end else if (idx_is_one) begin
                    state_next = S_INS_LAST;
                end
            end
            S_INS_LAST:   state_next = S_RESP;
            S_SRCH_ISSUE: state_next = srch_open ? S_SRCH_CMP : S_RESP;
            S_SRCH_CMP:   state_next = hit ? S_RESP : S_SRCH_ISSUE;
            S_RESP: begin
                if (rsp_ready) begin
                    state_next = S_IDLE;
                end
            end
            default:      state_next = S_IDLE;
        endcase
    end

    always_comb begin
        count_next  = count_reg;
        op_next     = op_reg;
        value_next  = value_reg;
        idx_next    = idx_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        pos_next    = pos_reg;
        status_next = status_reg;
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_data     = value_reg;
        rd_en       = 1'b0;
        rd_addr     = '0;
        case (state_reg)
            S_IDLE: begin
                if (req_valid) begin
                    op_next    = req.operation;
                    value_next = req.value;
                    lo_next    = '0;
                    hi_next    = count_reg;
                end
            end
            S_INS_START: begin
                if (is_full) begin
                    status_next = ST_FULL;
                    pos_next    = '0;
                end else if (is_empty) begin
                    wr_en       = 1'b1;
                    count_next  = count_reg + CW'(1);
                    status_next = ST_OK;
                    pos_next    = '0;
                end else begin
                    rd_en    = 1'b1;
                    rd_addr  = IW'(count_reg - CW'(1));
                    idx_next = IW'(count_reg);
                end
            end
            S_INS_SHIFT: begin
                wr_en   = 1'b1;
                wr_addr = idx_reg;
                if (shift_more) begin
                    wr_data  = rd_data_reg;
                    idx_next = idx_reg - IW'(1);
                    rd_en    = 1'b1;
                    rd_addr  = idx_reg - IW'(2);
                end else begin
                    count_next  = count_reg + CW'(1);
                    status_next = ST_OK;
                    pos_next    = idx_reg;
                end
            end
            S_INS_LAST: begin
                wr_en       = 1'b1;
                count_next  = count_reg + CW'(1);
                status_next = ST_OK;
                pos_next    = '0;
            end
            S_SRCH_ISSUE: begin
                if (srch_open) begin
                    rd_en    = 1'b1;
                    rd_addr  = mid_calc;
                    mid_next = mid_calc;
                end else begin
                    status_next = ST_ABSENT;
                    pos_next    = '0;
                end
            end
            S_SRCH_CMP: begin
                if (hit) begin
                    status_next = ST_OK;
                    pos_next    = mid_reg;
                end else if (value_reg < rd_data_reg) begin
                    hi_next = CW'(mid_reg);
                end else begin
                    lo_next = CW'(mid_reg) + CW'(1);
                end
            end
            S_RESP: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        value_reg  <= value_next;
        idx_reg    <= idx_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        pos_reg    <= pos_next;
        status_reg <= status_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign req_ready         = (state_reg == S_IDLE);
    assign rsp_valid         = (state_reg == S_RESP);
    assign rsp.status        = status_reg;
    assign rsp.position      = POS_W'(pos_reg);
    assign rsp.entries_used  = USED_W'(count_reg);

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("entry count exceeds table depth");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && (count_reg != $past(count_reg))
        |-> (count_reg == $past(count_reg) + CW'(1)))
        else $error("entry count moved by other than one");

    a_shift_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_INS_SHIFT) |-> (idx_reg != '0))
        else $error("shift target index reached zero");

    a_count_only_insert: assert property (@(posedge aclk) disable iff (!aresetn)
        (op_reg == OP_SEARCH) && (state_reg != S_IDLE) |=> $stable(count_reg))
        else $error("search changed the entry count");

endmodule

@@ src/sorted_table_insert_search.sv @@
// ----------------------------------------------------------------------------
// sorted_table_insert_search: sorted table with insert and binary search
// Stream front end around the table engine, with a registered result stage.
// ----------------------------------------------------------------------------
// An insert moves k entries up (one a cycle through the single write port),
// or none on an empty or full table. A search makes up to log2(TABLE_DEPTH) + 1
// probes, each a registered memory read followed by a compare.
// One request is in flight at a time; a new one is taken while a result waits.
// Reset (aresetn low, synchronous) empties the table; memory is not cleared.
module sorted_table_insert_search #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // value[31:0]
    input  logic [0:0]  s_tuser,   // operation[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // status[1:0], position[7:2], entries_used[14:8]
);
    import stis_pkg::*;

    req_t req;
    rsp_t rsp;
    logic rsp_valid;
    logic rsp_ready;
    logic out_valid_reg;
    rsp_t out_data_reg;

    assign req.operation = s_tuser[0];
    assign req.value     = s_tdata;

    stis_engine #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    assign rsp_ready = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (rsp_ready) begin
            out_valid_reg <= rsp_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (rsp_ready && rsp_valid) begin
            out_data_reg <= rsp;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_data_reg};

endmodule
